// ===== hw/rtl/esd_pkg.sv =====
// shared types and constants for the escape sequence decoder
`timescale 1ns / 1ps
`default_nettype none

package esd_pkg;

    // depth of the held digit store and its index width
    localparam int HELD_DEPTH = 8;
    localparam int IDX_W      = $clog2(HELD_DEPTH);

    // source of the next output word
    typedef enum logic [1:0] {
        SEL_BSLASH,
        SEL_LETTER,
        SEL_HELD,
        SEL_TAIL
    } t_out_sel;

    // controller to datapath commands
    typedef struct packed {
        logic             accept;
        logic             load;
        t_out_sel         sel;
        logic [IDX_W-1:0] idx;
        logic             final_word;
    } t_dp_cmd;

    // datapath to controller status: the emit plan of the word just taken
    typedef struct packed {
        logic             pre;
        logic [IDX_W-1:0] nheld;
        logic             tail;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== hw/rtl/esd_datapath.sv =====
// escape decoder datapath: parse state, digit store, emit plan and output register
`timescale 1ns / 1ps
`default_nettype none

module esd_datapath (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [7:0]          i_in_byte,
    input  wire logic                i_in_last,
    input  wire esd_pkg::t_dp_cmd    i_cmd,
    output esd_pkg::t_dp_status      o_status,
    output logic [7:0]               o_out_byte,
    output logic                     o_run_end,
    output logic                     o_string_end
);
    import esd_pkg::*;

    localparam logic [1:0] MODE_TEXT   = 2'd0;
    localparam logic [1:0] MODE_ESC    = 2'd1;
    localparam logic [1:0] MODE_DIGITS = 2'd2;

    localparam logic [2:0] KIND_BIN = 3'd0;
    localparam logic [2:0] KIND_OCT = 3'd1;
    localparam logic [2:0] KIND_DEC = 3'd2;
    localparam logic [2:0] KIND_HX2 = 3'd3;
    localparam logic [2:0] KIND_HX4 = 3'd4;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_O      = 8'h6F;
    localparam logic [7:0] CH_D      = 8'h64;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;

    // digit value of a character, 16 when it is no digit at all
    function automatic logic [4:0] digit_of(input logic [7:0] c);
        logic [4:0] d;
        d = 5'd16;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = 5'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = 5'(c - 8'h61) + 5'd10;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = 5'(c - 8'h41) + 5'd10;
        end
        return d;
    endfunction

    function automatic logic [4:0] kind_base(input logic [2:0] k);
        logic [4:0] b;
        unique case (k)
            KIND_OCT: b = 5'd8;
            KIND_DEC: b = 5'd10;
            KIND_HX2: b = 5'd16;
            KIND_HX4: b = 5'd16;
            default:  b = 5'd2;
        endcase
        return b;
    endfunction

    function automatic logic [3:0] kind_size(input logic [2:0] k);
        logic [3:0] s;
        unique case (k)
            KIND_OCT: s = 4'd3;
            KIND_DEC: s = 4'd3;
            KIND_HX2: s = 4'd2;
            KIND_HX4: s = 4'd4;
            default:  s = 4'd8;
        endcase
        return s;
    endfunction

    function automatic logic [7:0] kind_letter(input logic [2:0] k);
        logic [7:0] l;
        unique case (k)
            KIND_OCT: l = CH_O;
            KIND_DEC: l = CH_D;
            KIND_HX2: l = CH_X;
            KIND_HX4: l = CH_U;
            default:  l = CH_B;
        endcase
        return l;
    endfunction

    // value times base, done with shifts and at most one add
    function automatic logic [15:0] scale(input logic [15:0] v, input logic [2:0] k);
        logic [15:0] r;
        unique case (k)
            KIND_OCT: r = v << 3;
            KIND_DEC: r = (v << 3) + (v << 1);
            KIND_HX2: r = v << 4;
            KIND_HX4: r = v << 4;
            default:  r = v << 1;
        endcase
        return r;
    endfunction

    logic [1:0]       r_mode, n_mode;
    logic [2:0]       r_kind, n_kind;
    logic [IDX_W-1:0] r_count, n_count;
    logic [15:0]      r_value, n_value;
    logic [7:0]       r_held [HELD_DEPTH];
    logic             r_pre, n_pre;
    logic [IDX_W-1:0] r_nheld, n_nheld;
    logic             r_tail, n_tail;
    logic [7:0]       r_letter, n_letter;
    logic [7:0]       r_tail_byte, n_tail_byte;
    logic             r_last;
    logic             held_we;
    logic [4:0]       digit;
    logic [IDX_W:0]   count_inc;
    logic [15:0]      value_inc;
    logic [7:0]       r_out_byte;
    logic             r_run_end;
    logic             r_string_end;

    assign digit     = digit_of(i_in_byte);
    assign count_inc = {1'b0, r_count} + 1'b1;
    assign value_inc = scale(r_value, r_kind) + {11'd0, digit};

    // next parse state and emit plan for the incoming word
    always_comb begin
        n_mode      = r_mode;
        n_kind      = r_kind;
        n_count     = r_count;
        n_value     = r_value;
        n_pre       = r_pre;
        n_nheld     = r_nheld;
        n_tail      = r_tail;
        n_letter    = r_letter;
        n_tail_byte = r_tail_byte;
        held_we     = 1'b0;
        if (i_cmd.accept) begin
            n_pre       = 1'b0;
            n_nheld     = '0;
            n_tail      = 1'b0;
            n_letter    = i_in_byte;
            n_tail_byte = i_in_byte;
            n_mode      = MODE_TEXT;
            unique case (r_mode)
                MODE_ESC: begin
                    case (i_in_byte)
                        CH_R: begin
                            n_tail      = 1'b1;
                            n_tail_byte = CH_CR;
                        end
                        CH_N: begin
                            n_tail      = 1'b1;
                            n_tail_byte = CH_LF;
                        end
                        CH_ZERO: begin
                            n_tail      = 1'b1;
                            n_tail_byte = CH_NUL;
                        end
                        CH_T: begin
                            n_tail      = 1'b1;
                            n_tail_byte = CH_TAB;
                        end
                        CH_BSLASH: begin
                            n_tail = 1'b1;
                        end
                        CH_B, CH_O, CH_D, CH_X, CH_U: begin
                            if (i_in_last) begin
                                n_pre = 1'b1;
                            end else begin
                                n_mode  = MODE_DIGITS;
                                n_count = '0;
                                n_value = '0;
                                if (i_in_byte == CH_B) begin
                                    n_kind = KIND_BIN;
                                end else if (i_in_byte == CH_O) begin
                                    n_kind = KIND_OCT;
                                end else if (i_in_byte == CH_D) begin
                                    n_kind = KIND_DEC;
                                end else if (i_in_byte == CH_X) begin
                                    n_kind = KIND_HX2;
                                end else begin
                                    n_kind = KIND_HX4;
                                end
                            end
                        end
                        default: begin
                            n_pre = 1'b1;
                        end
                    endcase
                end
                MODE_DIGITS: begin
                    n_letter = kind_letter(r_kind);
                    n_count  = '0;
                    n_value  = '0;
                    if (digit < kind_base(r_kind)) begin
                        held_we = 1'b1;
                        if (count_inc >= kind_size(r_kind)) begin
                            n_tail      = 1'b1;
                            n_tail_byte = value_inc[7:0];
                        end else if (i_in_last) begin
                            n_pre   = 1'b1;
                            n_nheld = count_inc[IDX_W-1:0];
                        end else begin
                            n_mode  = MODE_DIGITS;
                            n_count = count_inc[IDX_W-1:0];
                            n_value = value_inc;
                        end
                    end else begin
                        // failed escape, then the byte again as text
                        n_pre   = 1'b1;
                        n_nheld = r_count;
                        if (i_in_byte == CH_BSLASH && !i_in_last) begin
                            n_mode = MODE_ESC;
                        end else begin
                            n_tail = 1'b1;
                        end
                    end
                end
                default: begin
                    if (i_in_byte == CH_BSLASH && !i_in_last) begin
                        n_mode = MODE_ESC;
                    end else begin
                        n_tail = 1'b1;
                    end
                end
            endcase
        end
    end

    // parse state and plan registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_TEXT;
            r_kind  <= KIND_BIN;
            r_count <= '0;
            r_value <= '0;
            r_pre   <= 1'b0;
            r_nheld <= '0;
            r_tail  <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_kind  <= n_kind;
            r_count <= n_count;
            r_value <= n_value;
            r_pre   <= n_pre;
            r_nheld <= n_nheld;
            r_tail  <= n_tail;
        end
    end

    // payload: letter, tail byte, end flag and digit store
    always_ff @(posedge i_clk) begin
        r_letter    <= n_letter;
        r_tail_byte <= n_tail_byte;
        if (i_cmd.accept) begin
            r_last <= i_in_last;
        end
        if (held_we) begin
            r_held[r_count] <= i_in_byte;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            case (i_cmd.sel)
                SEL_BSLASH: r_out_byte <= CH_BSLASH;
                SEL_LETTER: r_out_byte <= r_letter;
                SEL_HELD:   r_out_byte <= r_held[i_cmd.idx];
                default:    r_out_byte <= r_tail_byte;
            endcase
            r_run_end    <= i_cmd.final_word;
            r_string_end <= i_cmd.final_word & r_last;
        end
    end

    assign o_status.pre   = r_pre;
    assign o_status.nheld = r_nheld;
    assign o_status.tail  = r_tail;
    assign o_out_byte     = r_out_byte;
    assign o_run_end      = r_run_end;
    assign o_string_end   = r_string_end;

    // a final byte always leaves the parser in text mode
    a_last_to_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accept && i_in_last |=> r_mode == MODE_TEXT)
        else $error("parser not in text mode after final byte");

    // digits are only held while reading a numeric escape
    a_count_in_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != '0 |-> r_mode == MODE_DIGITS)
        else $error("digit count held outside digit mode");

    // held bytes are replayed only behind a backslash and letter
    a_held_needs_pre: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nheld != '0 |-> r_pre)
        else $error("held digits planned without escape prefix");

endmodule

`default_nettype wire

// ===== hw/rtl/esd_ctrl.sv =====
// escape decoder controller: input handshake and output word sequencing
`timescale 1ns / 1ps
`default_nettype none

module esd_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    input  wire esd_pkg::t_dp_status  i_status,
    output esd_pkg::t_dp_cmd          o_cmd
);
    import esd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_BSLASH,
        S_LETTER,
        S_HELD,
        S_TAIL
    } t_state;

    t_state           r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             slot_free;
    logic             held_done;
    t_dp_cmd          cmd;

    assign slot_free = !r_out_valid || i_out_ready;
    assign held_done = r_idx == IDX_W'(i_status.nheld - 1'b1);

    // next state and commands
    always_comb begin
        n_state        = r_state;
        n_idx          = r_idx;
        cmd            = '0;
        cmd.sel        = SEL_TAIL;
        cmd.idx        = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.accept = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                n_idx = '0;
                if (i_status.pre) begin
                    n_state = S_BSLASH;
                end else if (i_status.tail) begin
                    n_state = S_TAIL;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_BSLASH: begin
                if (slot_free) begin
                    cmd.load = 1'b1;
                    cmd.sel  = SEL_BSLASH;
                    n_state  = S_LETTER;
                end
            end
            S_LETTER: begin
                if (slot_free) begin
                    cmd.load       = 1'b1;
                    cmd.sel        = SEL_LETTER;
                    cmd.final_word = (i_status.nheld == '0) && !i_status.tail;
                    if (i_status.nheld != '0) begin
                        n_state = S_HELD;
                    end else if (i_status.tail) begin
                        n_state = S_TAIL;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_HELD: begin
                if (slot_free) begin
                    cmd.load       = 1'b1;
                    cmd.sel        = SEL_HELD;
                    cmd.final_word = held_done && !i_status.tail;
                    if (held_done) begin
                        n_state = i_status.tail ? S_TAIL : S_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_TAIL: begin
                if (slot_free) begin
                    cmd.load       = 1'b1;
                    cmd.sel        = SEL_TAIL;
                    cmd.final_word = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = cmd.load ? 1'b1 : (r_out_valid && !i_out_ready);
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    // a taken word always leads to the plan step
    a_accept_then_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_state == S_START)
        else $error("accepted word did not start its plan");

    // replay index stays inside the held digits
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_HELD |-> r_idx < i_status.nheld)
        else $error("held index beyond held digit count");

    // the final word of a run returns the sequencer to idle
    a_final_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load && cmd.final_word |=> r_state == S_IDLE && r_out_valid)
        else $error("sequencer not idle after final word");

endmodule

`default_nettype wire

// ===== hw/rtl/escape_sequence_decoder.sv =====
// Backslash escape decoder: takes one string byte per input word and returns 0 to 10
// decoded bytes. The escapes \r \n \0 \t and \\ give single bytes; \b, \o, \d, \x and \u
// read 8 binary, 3 octal, 3 decimal, 2 hex or 4 hex digits and give the low 8 bits of the
// value. A failed escape gives the backslash, its letter and the held digits, then the
// offending byte is decoded again as text. run_end marks the last output word of each
// input word and string_end the last one of the string. The controller handles one input
// word at a time and takes no new one until all of its output words are sent; the output
// sequencer sends one word per cycle from the single output register while the output
// side does not stall.
`timescale 1ns / 1ps
`default_nettype none

module escape_sequence_decoder (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_in_last,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_run_end,
    output logic            o_string_end
);
    import esd_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    // controller
    esd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // datapath
    esd_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_byte    (i_in_byte),
        .i_in_last    (i_in_last),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_out_byte   (o_out_byte),
        .o_run_end    (o_run_end),
        .o_string_end (o_string_end)
    );

endmodule

`default_nettype wire
